// ----- hw/rtl/sprpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sprpt_pkg;

  localparam int GRID_SIZE = 32;
  localparam int COORD_W   = 15;
  localparam int SCALE_W   = 11;
  localparam int PIX_W     = 5;
  localparam int ERR_W     = 36;
  localparam int MA_W      = 17;
  localparam int MB_W      = 13;

  localparam logic [4:0] OP_NONE  = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_DIV   = 5'd2;
  localparam logic [4:0] OP_SWAP  = 5'd3;
  localparam logic [4:0] OP_PREP  = 5'd4;
  localparam logic [4:0] OP_M0    = 5'd5;
  localparam logic [4:0] OP_M1    = 5'd6;
  localparam logic [4:0] OP_M2    = 5'd7;
  localparam logic [4:0] OP_M3    = 5'd8;
  localparam logic [4:0] OP_M4    = 5'd9;
  localparam logic [4:0] OP_VERT  = 5'd10;
  localparam logic [4:0] OP_WALK  = 5'd11;
  localparam logic [4:0] OP_TAIL  = 5'd12;
  localparam logic [4:0] OP_TWALK = 5'd13;
  localparam logic [4:0] OP_FIN   = 5'd14;
  localparam logic [4:0] OP_RERR  = 5'd15;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic range_bad;
    logic same_col;
    logic cond;
    logic col_done;
    logic cy_hi;
    logic stall;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sprpt_ray_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sprpt_ray_if;
  logic                             valid;
  logic                             ready;
  logic [sprpt_pkg::COORD_W-1:0]    begin_x;
  logic [sprpt_pkg::COORD_W-1:0]    begin_y;
  logic [sprpt_pkg::COORD_W-1:0]    end_x;
  logic [sprpt_pkg::COORD_W-1:0]    end_y;
  modport source (output valid, begin_x, begin_y, end_x, end_y, input ready);
  modport sink (input valid, begin_x, begin_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sprpt_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sprpt_pix_if;
  logic                           valid;
  logic                           ready;
  logic [sprpt_pkg::PIX_W-1:0]    pixel_x;
  logic [sprpt_pkg::PIX_W-1:0]    pixel_y;
  logic                           last;
  logic                           range_error;
  modport source (output valid, pixel_x, pixel_y, last, range_error, input ready);
  modport sink (input valid, pixel_x, pixel_y, last, range_error, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sprpt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sprpt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sprpt_pkg::sts_t sts,
  output sprpt_pkg::cmd_t      cmd
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIV   = 5'd1;
  localparam logic [4:0] ST_CHK   = 5'd2;
  localparam logic [4:0] ST_SWAP  = 5'd3;
  localparam logic [4:0] ST_PREP  = 5'd4;
  localparam logic [4:0] ST_M0    = 5'd5;
  localparam logic [4:0] ST_M1    = 5'd6;
  localparam logic [4:0] ST_M2    = 5'd7;
  localparam logic [4:0] ST_M3    = 5'd8;
  localparam logic [4:0] ST_M4    = 5'd9;
  localparam logic [4:0] ST_VERT  = 5'd10;
  localparam logic [4:0] ST_WALK  = 5'd11;
  localparam logic [4:0] ST_TAIL  = 5'd12;
  localparam logic [4:0] ST_TWALK = 5'd13;
  localparam logic [4:0] ST_FIN   = 5'd14;
  localparam logic [4:0] ST_ERR   = 5'd15;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = sprpt_pkg::OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = sprpt_pkg::OP_LOAD;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = sprpt_pkg::OP_DIV;
        if (sts.div_last) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = sts.range_bad ? ST_ERR : ST_SWAP;
      end
      ST_SWAP: begin
        cmd.op    = sprpt_pkg::OP_SWAP;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.op    = sprpt_pkg::OP_PREP;
        state_nxt = ST_M0;
      end
      ST_M0: begin
        cmd.op    = sprpt_pkg::OP_M0;
        state_nxt = sts.same_col ? ST_VERT : ST_M1;
      end
      ST_M1: begin
        cmd.op    = sprpt_pkg::OP_M1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.op    = sprpt_pkg::OP_M2;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.op    = sprpt_pkg::OP_M3;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        cmd.op    = sprpt_pkg::OP_M4;
        state_nxt = ST_WALK;
      end
      ST_VERT: begin
        cmd.op = sprpt_pkg::OP_VERT;
        if (!sts.stall && sts.cy_hi) state_nxt = ST_FIN;
      end
      ST_WALK: begin
        cmd.op = sprpt_pkg::OP_WALK;
        if (!sts.stall && !sts.cond && sts.col_done) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        cmd.op    = sprpt_pkg::OP_TAIL;
        state_nxt = ST_TWALK;
      end
      ST_TWALK: begin
        cmd.op = sprpt_pkg::OP_TWALK;
        if (!sts.stall && !sts.cond) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = sprpt_pkg::OP_FIN;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        cmd.op = sprpt_pkg::OP_RERR;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sprpt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sprpt_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sprpt_pkg::cmd_t               cmd,
  output sprpt_pkg::sts_t                    sts,
  input  wire logic                          cfg_we,
  input  wire logic [sprpt_pkg::SCALE_W-1:0] cfg_wdata,
  input  wire logic [sprpt_pkg::COORD_W-1:0] in_bx,
  input  wire logic [sprpt_pkg::COORD_W-1:0] in_by,
  input  wire logic [sprpt_pkg::COORD_W-1:0] in_ex,
  input  wire logic [sprpt_pkg::COORD_W-1:0] in_ey,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sprpt_pkg::PIX_W-1:0]        out_px,
  output logic [sprpt_pkg::PIX_W-1:0]        out_py,
  output logic                               out_last,
  output logic                               out_rerr
);

  localparam int CW = sprpt_pkg::COORD_W;
  localparam int SW = sprpt_pkg::SCALE_W;
  localparam int PW = sprpt_pkg::PIX_W;
  localparam int EW = sprpt_pkg::ERR_W;
  localparam int AW = sprpt_pkg::MA_W;
  localparam int BW = sprpt_pkg::MB_W;
  localparam int PRW = AW + BW;

  logic [SW-1:0] scale_r;
  logic [SW-1:0] s_eff;
  logic [SW:0]   s2;

  logic [CW-1:0] bx_r, by_r, ex_r, ey_r;
  logic [CW-1:0] qbx_r, qby_r, qex_r, qey_r;
  logic [SW-1:0] rbx_r, rby_r, rex_r, rey_r;

  logic [1:0]    dv_idx_r;
  logic [3:0]    dv_bit_r;
  logic [CW-1:0] dv_num_r, dv_num_nxt;
  logic [SW-1:0] dv_rem_r, dv_rem_nxt;
  logic [SW:0]   dv_trial;
  logic          dv_ge;
  logic          dv_end;

  logic [CW-1:0]     dx_r;
  logic signed [CW:0] dy_r;
  logic          dy_pos;
  logic [PW-1:0] cx_r, cy_r, endpx_r, hi_r;
  logic signed [EW-1:0] err_r, den_r, step_r, tailp_r;

  logic signed [AW-1:0]  ma;
  logic signed [BW-1:0]  mb;
  logic signed [PRW-1:0] prod;
  logic signed [EW-1:0]  prod_x;

  logic cond, eqc, col_done;
  logic [PW-1:0] cy_step;
  logic signed [EW-1:0] err_cond, err_base, err_add;

  logic          put_req, is_new, stall, out_free;
  logic          hv_r;
  logic [PW-1:0] hx_r, hy_r;
  logic          swap;
  logic [CW-1:0] qlo, qhi;

  assign s_eff = (scale_r == '0) ? SW'(1) : scale_r;
  assign s2    = {s_eff, 1'b0};

  // restoring divider, one quotient bit per cycle
  assign dv_trial   = {dv_rem_r, dv_num_r[CW-1]};
  assign dv_ge      = dv_trial >= {1'b0, s_eff};
  assign dv_rem_nxt = dv_ge ? SW'(dv_trial - {1'b0, s_eff}) : dv_trial[SW-1:0];
  assign dv_num_nxt = {dv_num_r[CW-2:0], dv_ge};
  assign dv_end     = (dv_bit_r == 4'(CW - 1));

  assign dy_pos   = dy_r > 0;
  assign cond     = dy_pos ? (err_r > den_r) : (err_r < 0);
  assign eqc      = dy_pos ? (err_r == den_r) : (err_r == 0);
  assign col_done = ({1'b0, cx_r} + 1'b1) >= {1'b0, endpx_r};
  assign cy_step  = dy_pos ? cy_r + 1'b1 : cy_r - 1'b1;
  assign err_cond = dy_pos ? err_r - den_r : err_r + den_r;
  assign err_base = eqc ? (dy_pos ? EW'(0) : den_r) : err_r;
  assign err_add  = col_done ? EW'(0) : step_r;

  assign put_req  = (cmd.op == sprpt_pkg::OP_VERT) || (cmd.op == sprpt_pkg::OP_WALK) ||
                    (cmd.op == sprpt_pkg::OP_TWALK);
  assign is_new   = !hv_r || (hx_r != cx_r) || (hy_r != cy_r);
  assign out_free = !out_valid || out_ready;
  assign stall    = put_req && is_new && hv_r && !out_free;

  assign swap = bx_r > ex_r;
  assign qlo  = (qby_r < qey_r) ? qby_r : qey_r;
  assign qhi  = (qby_r < qey_r) ? qey_r : qby_r;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      sprpt_pkg::OP_M0: begin
        ma = AW'(signed'({1'b0, dx_r}));
        mb = BW'(signed'({1'b0, s2}));
      end
      sprpt_pkg::OP_M1: begin
        ma = AW'(signed'({1'b0, dx_r}));
        mb = BW'(signed'({2'b0, rby_r, 1'b1}));
      end
      sprpt_pkg::OP_M2: begin
        ma = AW'(dy_r);
        mb = BW'(signed'({1'b0, (SW + 1)'(s2 - {rbx_r, 1'b1})}));
      end
      sprpt_pkg::OP_M3: begin
        ma = AW'(dy_r);
        mb = BW'(signed'({1'b0, s2}));
      end
      sprpt_pkg::OP_M4: begin
        ma = AW'(dy_r);
        mb = BW'(signed'({2'b0, rex_r, 1'b1}));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_x = EW'(prod);

  assign sts.div_last  = (cmd.op == sprpt_pkg::OP_DIV) && dv_end && (dv_idx_r == 2'd3);
  assign sts.range_bad = (qbx_r >= CW'(sprpt_pkg::GRID_SIZE)) ||
                         (qby_r >= CW'(sprpt_pkg::GRID_SIZE)) ||
                         (qex_r >= CW'(sprpt_pkg::GRID_SIZE)) ||
                         (qey_r >= CW'(sprpt_pkg::GRID_SIZE));
  assign sts.same_col  = (cx_r == endpx_r);
  assign sts.cond      = cond;
  assign sts.col_done  = col_done;
  assign sts.cy_hi     = (cy_r == hi_r);
  assign sts.stall     = stall;
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SW'(1);
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      sprpt_pkg::OP_LOAD: begin
        bx_r     <= in_bx;
        by_r     <= in_by;
        ex_r     <= in_ex;
        ey_r     <= in_ey;
        dv_idx_r <= 2'd0;
        dv_bit_r <= 4'd0;
        dv_num_r <= in_bx;
        dv_rem_r <= '0;
      end
      sprpt_pkg::OP_DIV: begin
        if (dv_end) begin
          case (dv_idx_r)
            2'd0: begin qbx_r <= dv_num_nxt; rbx_r <= dv_rem_nxt; dv_num_r <= by_r; end
            2'd1: begin qby_r <= dv_num_nxt; rby_r <= dv_rem_nxt; dv_num_r <= ex_r; end
            2'd2: begin qex_r <= dv_num_nxt; rex_r <= dv_rem_nxt; dv_num_r <= ey_r; end
            default: begin qey_r <= dv_num_nxt; rey_r <= dv_rem_nxt; end
          endcase
          dv_idx_r <= dv_idx_r + 1'b1;
          dv_bit_r <= 4'd0;
          dv_rem_r <= '0;
        end else begin
          dv_bit_r <= dv_bit_r + 1'b1;
          dv_num_r <= dv_num_nxt;
          dv_rem_r <= dv_rem_nxt;
        end
      end
      sprpt_pkg::OP_SWAP: begin
        if (swap) begin
          bx_r <= ex_r; ex_r <= bx_r; by_r <= ey_r; ey_r <= by_r;
          qbx_r <= qex_r; qex_r <= qbx_r; qby_r <= qey_r; qey_r <= qby_r;
          rbx_r <= rex_r; rex_r <= rbx_r; rby_r <= rey_r; rey_r <= rby_r;
        end
      end
      sprpt_pkg::OP_PREP: begin
        dx_r    <= ex_r - bx_r;
        dy_r    <= signed'({1'b0, ey_r}) - signed'({1'b0, by_r});
        cx_r    <= qbx_r[PW-1:0];
        endpx_r <= qex_r[PW-1:0];
        hi_r    <= qhi[PW-1:0];
        cy_r    <= (qbx_r == qex_r) ? qlo[PW-1:0] : qby_r[PW-1:0];
      end
      sprpt_pkg::OP_M0: den_r   <= prod_x;
      sprpt_pkg::OP_M1: err_r   <= prod_x;
      sprpt_pkg::OP_M2: err_r   <= err_r + prod_x;
      sprpt_pkg::OP_M3: step_r  <= prod_x;
      sprpt_pkg::OP_M4: tailp_r <= prod_x;
      sprpt_pkg::OP_VERT: begin
        if (!stall && !sts.cy_hi) cy_r <= cy_r + 1'b1;
      end
      sprpt_pkg::OP_WALK: begin
        if (!stall) begin
          if (cond) begin
            err_r <= err_cond;
            cy_r  <= cy_step;
          end else begin
            cx_r  <= cx_r + 1'b1;
            err_r <= err_base + err_add;
            if (eqc) cy_r <= cy_step;
          end
        end
      end
      sprpt_pkg::OP_TAIL: err_r <= err_r + tailp_r;
      sprpt_pkg::OP_TWALK: begin
        if (!stall && cond) begin
          err_r <= err_cond;
          cy_r  <= cy_step;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (put_req && !stall && is_new) begin
        hv_r <= 1'b1;
      end else if (cmd.op == sprpt_pkg::OP_FIN && out_free) begin
        hv_r <= 1'b0;
      end
      if ((put_req && !stall && is_new && hv_r) ||
          ((cmd.op == sprpt_pkg::OP_FIN || cmd.op == sprpt_pkg::OP_RERR) && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_req && !stall && is_new) begin
      hx_r <= cx_r;
      hy_r <= cy_r;
      if (hv_r) begin
        out_px   <= hx_r;
        out_py   <= hy_r;
        out_last <= 1'b0;
        out_rerr <= 1'b0;
      end
    end else if (cmd.op == sprpt_pkg::OP_FIN && out_free) begin
      out_px   <= hx_r;
      out_py   <= hy_r;
      out_last <= 1'b1;
      out_rerr <= 1'b0;
    end else if (cmd.op == sprpt_pkg::OP_RERR && out_free) begin
      out_px   <= '0;
      out_py   <= '0;
      out_last <= 1'b1;
      out_rerr <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/subpixel_ray_pixel_traversal_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Subpixel ray to pixel traversal.
// in_ray carries one ray (begin and end point in subpixel units); out_pix
// carries the crossed pixels in order, low x first, with last on the final
// one. A ray with an endpoint outside the 32x32 grid gives a single result
// with range_error and last set. cfg_we/cfg_wdata write subpixel_scale
// (0 acts as 1); write it only while the block is idle.
// One ray at a time: in_ray.ready is high only while idle. After a transfer
// the four endpoint coordinates are divided by the scale in turn on a shared
// restoring divider, then come a range check, an endpoint swap, a prep step
// and the products on the shared multiplier (only the first one when both
// ends lie in one pixel column). The walk emits up to one pixel per cycle
// while the receiver keeps up.
// Results leave through an output register; a stalled receiver holds the
// walk until the register frees up, nothing is dropped.
// Synchronous reset sets the scale to 1 and returns the block to idle with
// no result pending.
module subpixel_ray_pixel_traversal_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sprpt_pkg::SCALE_W-1:0] cfg_wdata,
  sprpt_ray_if.sink                          in_ray,
  sprpt_pix_if.source                        out_pix
);

  sprpt_pkg::cmd_t cmd;
  sprpt_pkg::sts_t sts;

  sprpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ray.valid),
    .in_ready (in_ray.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sprpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bx     (in_ray.begin_x),
    .in_by     (in_ray.begin_y),
    .in_ex     (in_ray.end_x),
    .in_ey     (in_ray.end_y),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .out_px    (out_pix.pixel_x),
    .out_py    (out_pix.pixel_y),
    .out_last  (out_pix.last),
    .out_rerr  (out_pix.range_error)
  );

endmodule
`default_nettype wire
